@@ design/aodf_pkg.sv @@
// Shared constants, register indexes and types of the ADC oversampling deadband filter.
package aodf_pkg;

  localparam int CHANNELS        = 8;
  localparam int MUX_SELECT_BITS = 0;
  localparam int GROUPS          = 1 << MUX_SELECT_BITS;
  localparam int PINS            = CHANNELS * GROUPS;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int PIN_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int GROUP_W  = 3;
  localparam int PASS_W   = 4;
  localparam int BAND_W   = 8;
  localparam int RATE_W   = 5;
  localparam int NCH_W    = 4;
  localparam int PIDX_W   = (PINS > 1) ? $clog2(PINS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DEADBAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RELOAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USED_CHANNELS   = 3'd4;

  localparam logic [BAND_W-1:0]  DEADBAND_RST      = 8'd31;
  localparam logic [BAND_W-1:0]  IDLE_DEADBAND_RST = 8'd0;
  localparam logic [VALUE_W-1:0] IDLE_RELOAD_RST   = 16'd100;
  localparam logic [RATE_W-1:0]  RATE_RST          = 5'd1;
  localparam logic [NCH_W-1:0]   USED_CH_RST       = 4'd8;

  localparam logic [RATE_W-1:0]  RATE_MAX    = 5'd16;
  localparam logic [VALUE_W-1:0] SPIKE_LIMIT = 16'd64;
  localparam logic [GROUP_W-1:0] GROUP_MASK  = GROUP_W'(GROUPS - 1);

  // One entry of the per-pin memory.
  typedef struct packed {
    logic [VALUE_W-1:0] spike_last;
    logic [VALUE_W-1:0] held;
    logic [VALUE_W-1:0] idle_count;
  } pin_entry_t;

endpackage

@@ design/aodf_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface aodf_in_if;
  logic                          valid;
  logic                          ready;
  logic [aodf_pkg::SAMPLE_W-1:0] sample;
  logic [aodf_pkg::CHAN_W-1:0]   channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface aodf_out_if;
  logic                         valid;
  logic                         ready;
  logic [aodf_pkg::PIN_W-1:0]   pin;
  logic [aodf_pkg::VALUE_W-1:0] held_value;
  logic                         changed;

  modport source (output valid, output pin, output held_value, output changed, input ready);
  modport sink   (input valid, input pin, input held_value, input changed, output ready);
endinterface

@@ design/aodf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module aodf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/adc_oversample_deadband_filter.sv @@
// Top level of the ADC oversampling filter with spike rejection and deadband hysteresis.
//
// Usage: ADC conversions arrive on in_chan (valid/ready), each a 12-bit sample tagged
// with its channel within the scan. A transfer on in_chan is taken whenever the first
// pipeline stage is empty or moving on. Samples of channels at or above the used channel
// count are taken and dropped. On the final pass of each oversampling cycle every sample
// yields one result on out_chan: the pin number, its held value and a changed flag.
// A result passes from the first stage into the output register before it is offered.
// Throughput: one sample per cycle while out_chan does not stall. The per-channel sums
// and the per-pin filter state live in two small RAMs with registered read data; a sample
// reads in its transfer cycle and writes back as it leaves the first stage, and a write to
// the same entry that lands on the edge of a read is forwarded into the reading stage.
// When out_chan stalls, a final-pass sample waits in the first stage and in_chan ready
// drops; non-final samples still drain, since they produce no result.
// Reset (synchronous, rst_n low) restores the configuration defaults, clears the pass
// and group counters and marks every RAM entry as unwritten, so it reads as zero; no
// clearing pass is needed. Configuration writes on cfg_we/cfg_index/cfg_wdata take
// effect at once and are to be made only while the block is idle.
module adc_oversample_deadband_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  aodf_in_if.sink                             in_chan,
  aodf_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [aodf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aodf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [aodf_pkg::BAND_W-1:0]  deadband_r;
  logic [aodf_pkg::BAND_W-1:0]  idle_deadband_r;
  logic [aodf_pkg::VALUE_W-1:0] idle_reload_r;
  logic [aodf_pkg::RATE_W-1:0]  oversample_rate_r;
  logic [aodf_pkg::NCH_W-1:0]   used_channels_r;

  // Scan counters.
  logic [aodf_pkg::PASS_W-1:0]  pass_count_r;
  logic [aodf_pkg::GROUP_W-1:0] group_count_r;

  // Written-since-reset flags for each RAM entry.
  logic [aodf_pkg::CHANNELS-1:0] sum_valid_r;
  logic [aodf_pkg::PINS-1:0]     pin_valid_r;

  // First stage: item whose RAM reads are in flight.
  logic                           s1_valid_r;
  logic [aodf_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic [aodf_pkg::CHAN_W-1:0]    s1_chan_r;
  logic [aodf_pkg::PIN_W-1:0]     s1_pin_r;
  logic [aodf_pkg::PIDX_W-1:0]    s1_pidx_r;
  logic                           s1_first_r;
  logic                           s1_final_r;
  logic                           s1_pin_ok_r;
  logic                           s1_sum_vld_r;
  logic                           s1_sum_byp_r;
  logic [aodf_pkg::VALUE_W-1:0]   s1_sum_byp_data_r;
  logic                           s1_pin_vld_r;
  logic                           s1_pin_byp_r;
  aodf_pkg::pin_entry_t           s1_pin_byp_data_r;

  // Output register.
  logic                          out_valid_r;
  logic [aodf_pkg::PIN_W-1:0]    out_pin_r;
  logic [aodf_pkg::VALUE_W-1:0]  out_held_r;
  logic                          out_changed_r;

  // Effective configuration after limiting.
  logic [aodf_pkg::RATE_W-1:0] rate_eff;
  logic [aodf_pkg::NCH_W-1:0]  nch_eff;

  always_comb begin
    if (oversample_rate_r == '0) begin
      rate_eff = aodf_pkg::RATE_W'(1);
    end else if (oversample_rate_r > aodf_pkg::RATE_MAX) begin
      rate_eff = aodf_pkg::RATE_MAX;
    end else begin
      rate_eff = oversample_rate_r;
    end
    if (used_channels_r == '0) begin
      nch_eff = aodf_pkg::NCH_W'(1);
    end else if (used_channels_r > aodf_pkg::NCH_W'(aodf_pkg::CHANNELS)) begin
      nch_eff = aodf_pkg::NCH_W'(aodf_pkg::CHANNELS);
    end else begin
      nch_eff = used_channels_r;
    end
  end

  // Input side: classify the offered sample.
  logic                         in_take;
  logic                         chan_used;
  logic                         final_pass;
  logic                         end_of_pass;
  logic [aodf_pkg::PIN_W:0]     pin_full;
  logic [aodf_pkg::PIDX_W-1:0]  in_pidx;
  logic                         in_pin_ok;
  logic                         s1_adv;
  logic                         in_ready;

  always_comb begin
    chan_used   = {1'b0, in_chan.channel} < nch_eff;
    final_pass  = ({1'b0, pass_count_r} + aodf_pkg::RATE_W'(1)) >= rate_eff;
    end_of_pass = {1'b0, in_chan.channel} == (nch_eff - aodf_pkg::NCH_W'(1));
    pin_full    = (aodf_pkg::PIN_W + 1)'(group_count_r & aodf_pkg::GROUP_MASK)
                  * (aodf_pkg::PIN_W + 1)'(nch_eff)
                  + (aodf_pkg::PIN_W + 1)'(in_chan.channel);
    in_pin_ok   = pin_full < (aodf_pkg::PIN_W + 1)'(aodf_pkg::PINS);
    in_pidx     = pin_full[aodf_pkg::PIDX_W-1:0];
  end

  // A final-pass item with a pin needs the output register; others just write back.
  assign s1_adv   = !(s1_final_r && s1_pin_ok_r) || !out_valid_r || out_chan.ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_chan.ready = in_ready;
  assign in_take  = in_chan.valid && in_ready && chan_used;

  // Second stage: read-modify-write of the sum and the pin entry.
  logic                         commit;
  logic [aodf_pkg::VALUE_W-1:0] sum_rdata;
  aodf_pkg::pin_entry_t         pin_rdata;
  logic [aodf_pkg::VALUE_W-1:0] sum_old;
  logic [aodf_pkg::VALUE_W-1:0] sum_new;
  aodf_pkg::pin_entry_t         pin_old;
  aodf_pkg::pin_entry_t         pin_new;
  logic                         pin_we;
  logic                         changed;
  logic                         idle_on;
  logic [aodf_pkg::BAND_W-1:0]  band;
  logic [aodf_pkg::VALUE_W-1:0] spike_diff;
  logic [aodf_pkg::VALUE_W-1:0] held_diff;

  assign commit = s1_valid_r && s1_adv;
  assign pin_we = commit && s1_final_r && s1_pin_ok_r;

  always_comb begin
    if (s1_sum_byp_r) begin
      sum_old = s1_sum_byp_data_r;
    end else if (s1_sum_vld_r) begin
      sum_old = sum_rdata;
    end else begin
      sum_old = '0;
    end
    if (s1_pin_byp_r) begin
      pin_old = s1_pin_byp_data_r;
    end else if (s1_pin_vld_r) begin
      pin_old = pin_rdata;
    end else begin
      pin_old = '0;
    end

    // The first pass of a cycle restarts the sum.
    if (s1_first_r) begin
      sum_new = aodf_pkg::VALUE_W'(s1_sample_r);
    end else begin
      sum_new = sum_old + aodf_pkg::VALUE_W'(s1_sample_r);
    end

    idle_on = idle_deadband_r != '0;
    band    = (idle_on && pin_old.idle_count == '0) ? idle_deadband_r : deadband_r;

    spike_diff = (pin_old.spike_last >= sum_new) ? pin_old.spike_last - sum_new
                                                 : sum_new - pin_old.spike_last;
    held_diff  = (sum_new >= pin_old.held) ? sum_new - pin_old.held
                                           : pin_old.held - sum_new;

    // The last raw sum is always replaced; a spike leaves the held value alone.
    pin_new            = pin_old;
    pin_new.spike_last = sum_new;
    changed            = 1'b0;
    if (spike_diff < aodf_pkg::SPIKE_LIMIT) begin
      if (held_diff > aodf_pkg::VALUE_W'(band)) begin
        pin_new.held = sum_new;
        changed      = 1'b1;
        if (idle_on) begin
          pin_new.idle_count = idle_reload_r;
        end
      end else if (idle_on && pin_old.idle_count != '0) begin
        pin_new.idle_count = pin_old.idle_count - aodf_pkg::VALUE_W'(1);
      end
    end
  end

  aodf_ram #(
    .WIDTH (aodf_pkg::VALUE_W),
    .DEPTH (aodf_pkg::CHANNELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (s1_chan_r),
    .wdata (sum_new),
    .re    (in_take),
    .raddr (in_chan.channel),
    .rdata (sum_rdata)
  );

  aodf_ram #(
    .WIDTH ($bits(aodf_pkg::pin_entry_t)),
    .DEPTH (aodf_pkg::PINS)
  ) u_pin_ram (
    .clk   (clk),
    .we    (pin_we),
    .waddr (s1_pidx_r),
    .wdata (pin_new),
    .re    (in_take),
    .raddr (in_pidx),
    .rdata (pin_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r        <= aodf_pkg::DEADBAND_RST;
      idle_deadband_r   <= aodf_pkg::IDLE_DEADBAND_RST;
      idle_reload_r     <= aodf_pkg::IDLE_RELOAD_RST;
      oversample_rate_r <= aodf_pkg::RATE_RST;
      used_channels_r   <= aodf_pkg::USED_CH_RST;
      pass_count_r      <= '0;
      group_count_r     <= '0;
      sum_valid_r       <= '0;
      pin_valid_r       <= '0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aodf_pkg::CFG_DEADBAND:        deadband_r        <= cfg_wdata[aodf_pkg::BAND_W-1:0];
          aodf_pkg::CFG_IDLE_DEADBAND:   idle_deadband_r   <= cfg_wdata[aodf_pkg::BAND_W-1:0];
          aodf_pkg::CFG_IDLE_RELOAD:     idle_reload_r     <= cfg_wdata[aodf_pkg::VALUE_W-1:0];
          aodf_pkg::CFG_OVERSAMPLE_RATE: oversample_rate_r <= cfg_wdata[aodf_pkg::RATE_W-1:0];
          aodf_pkg::CFG_USED_CHANNELS:   used_channels_r   <= cfg_wdata[aodf_pkg::NCH_W-1:0];
          default: ;
        endcase
      end

      if (in_take && end_of_pass) begin
        if (final_pass) begin
          pass_count_r  <= '0;
          group_count_r <= (group_count_r + aodf_pkg::GROUP_W'(1)) & aodf_pkg::GROUP_MASK;
        end else begin
          pass_count_r  <= pass_count_r + aodf_pkg::PASS_W'(1);
        end
      end

      if (commit) begin
        sum_valid_r[s1_chan_r] <= 1'b1;
      end
      if (pin_we) begin
        pin_valid_r[s1_pidx_r] <= 1'b1;
      end

      if (in_ready) begin
        s1_valid_r <= in_take;
      end

      if (pin_we) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers. A write landing on the edge of a read of the same entry is
  // captured here, since the RAM returns the old contents in that case.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r       <= in_chan.sample;
      s1_chan_r         <= in_chan.channel;
      s1_pin_r          <= pin_full[aodf_pkg::PIN_W-1:0];
      s1_pidx_r         <= in_pidx;
      s1_first_r        <= pass_count_r == '0;
      s1_final_r        <= final_pass;
      s1_pin_ok_r       <= in_pin_ok;
      s1_sum_vld_r      <= sum_valid_r[in_chan.channel];
      s1_sum_byp_r      <= commit && (s1_chan_r == in_chan.channel);
      s1_sum_byp_data_r <= sum_new;
      s1_pin_vld_r      <= pin_valid_r[in_pidx];
      s1_pin_byp_r      <= pin_we && (s1_pidx_r == in_pidx);
      s1_pin_byp_data_r <= pin_new;
    end
    if (pin_we) begin
      out_pin_r     <= s1_pin_r;
      out_held_r    <= pin_new.held;
      out_changed_r <= changed;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pin        = out_pin_r;
  assign out_chan.held_value = out_held_r;
  assign out_chan.changed    = out_changed_r;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the ADC oversampling filter with spike and deadband hysteresis.
`timescale 1ns / 1ps

module tb;
  import aodf_pkg::*;

  // The run is cut off here if the drain at the end never completes.
  localparam int CYCLE_LIMIT = 400000;
  // The result register sits behind the first stage, and the RAM write-back happens as an
  // item leaves that stage, so QUIET_CYCLES spare cycles cover any silent work.
  localparam int QUIET_CYCLES = 4;
  localparam int MAX_GAP = 40;

  typedef struct packed {
    logic [PIN_W-1:0]   pin;
    logic [VALUE_W-1:0] held;
    logic               changed;
  } pin_report_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aodf_in_if  in_if ();
  aodf_out_if out_if ();

  adc_oversample_deadband_filter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration registers, as last written.
  logic [BAND_W-1:0]  deadband_r;
  logic [BAND_W-1:0]  idle_band_r;
  logic [VALUE_W-1:0] idle_reload_r;
  logic [RATE_W-1:0]  rate_r;
  logic [NCH_W-1:0]   used_r;

  // Shadow copy of the filter state.
  logic [VALUE_W-1:0] acc_sum [CHANNELS];
  logic [PASS_W-1:0]  pass_cnt;
  logic [GROUP_W-1:0] group_cnt;
  logic [VALUE_W-1:0] held_val [PINS];
  logic [VALUE_W-1:0] idle_left [PINS];
  logic [VALUE_W-1:0] last_raw [PINS];

  // Pin reports that the block still owes, oldest first.
  pin_report_t reports_due[$];
  pin_report_t due;

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  // Slowly drifting signal level of each channel, used to build realistic scans.
  int chan_level [CHANNELS];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d reports outstanding", $time, reports_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // The receiver stalls with the probability of the current phase. The new
  // ready value is set at the falling edge so the block sees it settled.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result transfer is compared with the oldest report still owed.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result: pin %0d held %0d changed %0b", $time,
                 out_if.pin, out_if.held_value, out_if.changed);
        error_count++;
      end else begin
        due = reports_due.pop_front();
        if (out_if.pin !== due.pin) begin
          $display("%0t: pin mismatch: expected %0d actual %0d", $time, due.pin, out_if.pin);
          error_count++;
        end
        if (out_if.held_value !== due.held) begin
          $display("%0t: held value mismatch on pin %0d: expected %0d actual %0d", $time,
                   due.pin, due.held, out_if.held_value);
          error_count++;
        end
        if (out_if.changed !== due.changed) begin
          $display("%0t: changed flag mismatch on pin %0d: expected %0b actual %0b", $time,
                   due.pin, due.changed, out_if.changed);
          error_count++;
        end
      end
    end
  end

  // Register values outside the legal range are limited by the block.
  function automatic int eff_rate();
    if (rate_r == 0) return 1;
    if (rate_r > RATE_MAX) return int'(RATE_MAX);
    return int'(rate_r);
  endfunction

  function automatic int eff_channels();
    if (used_r == 0) return 1;
    if (used_r > CHANNELS) return CHANNELS;
    return int'(used_r);
  endfunction

  function automatic int abs_gap(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  // Predicts what one accepted sample does to the filter, and queues the pin
  // report that it causes on the final pass of an oversampling cycle.
  task automatic filter_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch);
    int nch;
    int rate;
    int pin;
    int band;
    int spike;
    logic final_pass;
    logic idle_on;
    logic [VALUE_W-1:0] sum;
    pin_report_t rep;
    nch = eff_channels();
    rate = eff_rate();
    // Channels beyond the used count leave every part of the state alone.
    if (int'(ch) >= nch) return;
    if (pass_cnt == 0) acc_sum[ch] = VALUE_W'(smp);
    else acc_sum[ch] = acc_sum[ch] + VALUE_W'(smp);
    // A rate lowered in mid cycle makes the current pass final at once.
    final_pass = (int'(pass_cnt) + 1) >= rate;
    if (final_pass) begin
      pin = int'(group_cnt & GROUP_MASK) * nch + int'(ch);
      if (pin < PINS) begin
        sum = acc_sum[ch];
        idle_on = (idle_band_r != 0);
        band = (idle_on && idle_left[pin] == 0) ? int'(idle_band_r) : int'(deadband_r);
        spike = abs_gap(int'(last_raw[pin]), int'(sum));
        // The last raw sum is replaced even when this one is thrown out as a spike.
        last_raw[pin] = sum;
        rep.changed = 1'b0;
        if (spike < int'(SPIKE_LIMIT)) begin
          if (abs_gap(int'(sum), int'(held_val[pin])) > band) begin
            held_val[pin] = sum;
            rep.changed = 1'b1;
            if (idle_on) idle_left[pin] = idle_reload_r;
          end else if (idle_on && idle_left[pin] != 0) begin
            idle_left[pin] = idle_left[pin] - 1'b1;
          end
        end
        rep.pin = PIN_W'(pin);
        rep.held = held_val[pin];
        reports_due.push_back(rep);
      end
    end
    // The scan pass ends on the top used channel, whatever order came before.
    if (int'(ch) == nch - 1) begin
      if (final_pass) begin
        pass_cnt = '0;
        group_cnt = (group_cnt + 1'b1) & GROUP_MASK;
      end else begin
        pass_cnt = pass_cnt + 1'b1;
      end
    end
  endtask

  // Offers one sample after a random gap and waits for its transfer. Valid is
  // left high so that back-to-back samples follow without a gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.sample  <= smp;
    in_if.channel <= ch;
    do @(posedge clk); while (!in_if.ready);
    filter_sample(smp, ch);
  endtask

  // Stops the sender and waits until every owed report has arrived and any
  // silent work on ignored or non-final samples has finished.
  task automatic wait_quiet();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes one register; callers make sure the block is idle first.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEADBAND:        deadband_r    = val[BAND_W-1:0];
      CFG_IDLE_DEADBAND:   idle_band_r   = val[BAND_W-1:0];
      CFG_IDLE_RELOAD:     idle_reload_r = val[VALUE_W-1:0];
      CFG_OVERSAMPLE_RATE: rate_r        = val[RATE_W-1:0];
      CFG_USED_CHANNELS:   used_r        = val[NCH_W-1:0];
      default: ;
    endcase
  endtask

  // One scan of all used channels in ascending order, each channel drifting by
  // up to step counts from its level, with an occasional spike sample.
  task automatic send_scan(input int step, output int used_sent);
    int nch;
    int c;
    int smp;
    nch = eff_channels();
    used_sent = 0;
    for (c = 0; c < nch; c++) begin
      chan_level[c] = clamp_sample(chan_level[c] + int'($urandom_range(0, 2 * step)) - step);
      if ($urandom_range(99) < 3) smp = int'($urandom_range(0, 4095));
      else smp = clamp_sample(chan_level[c] + int'($urandom_range(0, 2)) - 1);
      send_sample(SAMPLE_W'(smp), CHAN_W'(c));
      used_sent++;
    end
  endtask

  // Picks a setting for a stretch of random traffic. Slow rates are paired
  // with few channels so that results keep coming.
  task automatic pick_settings();
    int roll;
    logic [RATE_W-1:0] rate_w;
    logic [NCH_W-1:0]  used_w;
    roll = $urandom_range(9);
    if (roll < 3) write_reg(CFG_DEADBAND, (roll == 0) ? 16'd0 : 16'd255);
    else write_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(0, 40)));
    roll = $urandom_range(9);
    if (roll < 3) write_reg(CFG_IDLE_DEADBAND, 16'd0);
    else if (roll == 3) write_reg(CFG_IDLE_DEADBAND, 16'd255);
    else write_reg(CFG_IDLE_DEADBAND, CFG_DATA_W'($urandom_range(1, 80)));
    roll = $urandom_range(9);
    if (roll == 0) write_reg(CFG_IDLE_RELOAD, 16'hffff);
    else if (roll == 1) write_reg(CFG_IDLE_RELOAD, CFG_DATA_W'($urandom_range(0, 65535)));
    else write_reg(CFG_IDLE_RELOAD, CFG_DATA_W'($urandom_range(0, 4)));
    roll = $urandom_range(9);
    if (roll < 7) rate_w = RATE_W'($urandom_range(1, 4));
    else if (roll == 7) rate_w = '0;
    else rate_w = RATE_W'($urandom_range(5, 31));
    write_reg(CFG_OVERSAMPLE_RATE, CFG_DATA_W'(rate_w));
    if (eff_rate() > 4) used_w = NCH_W'($urandom_range(0, 2));
    else if ($urandom_range(9) < 7) used_w = NCH_W'($urandom_range(1, CHANNELS));
    else used_w = NCH_W'($urandom_range(0, 15));
    write_reg(CFG_USED_CHANNELS, CFG_DATA_W'(used_w));
  endtask

  // Directed samples at the reset settings: the spike limit and the default
  // deadband are probed on both sides of their boundaries.
  task automatic test_reset_settings();
    send_sample(12'd0, 3'd0);     // no change against the cleared held value
    send_sample(12'd4095, 3'd1);  // full-scale jump from zero is a spike
    send_sample(12'd40, 3'd2);    // outside the deadband and below the spike limit
    send_sample(12'd31, 3'd3);    // equal to the deadband, so not taken
    send_sample(12'd32, 3'd4);    // one past the deadband
    send_sample(12'd63, 3'd5);    // largest jump that is not a spike
    send_sample(12'd64, 3'd6);    // smallest jump that counts as a spike
    send_sample(12'd4095, 3'd7);
    wait_quiet();
  endtask

  // Unused channels, channels out of order, a rate lowered in mid cycle and
  // register values outside their legal ranges.
  task automatic test_corner_settings();
    write_reg(CFG_USED_CHANNELS, 16'd3);
    write_reg(CFG_OVERSAMPLE_RATE, 16'd4);
    send_sample(12'd500, 3'd5);   // beyond the used count: dropped
    send_sample(12'd20, 3'd1);
    send_sample(12'd10, 3'd0);
    send_sample(12'd30, 3'd2);    // ends the first pass of four
    wait_quiet();
    // The pass counter now stands at one, so a rate of two makes the next pass final.
    write_reg(CFG_OVERSAMPLE_RATE, 16'd2);
    send_sample(12'd15, 3'd0);
    send_sample(12'd25, 3'd1);
    send_sample(12'd35, 3'd2);
    wait_quiet();
    // A rate of zero acts as one and a count of zero as a single channel.
    write_reg(CFG_OVERSAMPLE_RATE, 16'd0);
    write_reg(CFG_USED_CHANNELS, 16'd0);
    write_reg(CFG_DEADBAND, 16'd0);
    write_reg(CFG_IDLE_DEADBAND, 16'd255);
    write_reg(CFG_IDLE_RELOAD, 16'd0);
    send_sample(12'd40, 3'd0);
    send_sample(12'd41, 3'd0);
    send_sample(12'd900, 3'd1);   // dropped
    send_sample(12'd42, 3'd0);
    wait_quiet();
  endtask

  // The slowest settings: a rate above the top acts as sixteen, and a channel
  // count above the top acts as all channels. Full-scale sums hit the largest value.
  task automatic test_slowest_rate();
    int k;
    int c;
    write_reg(CFG_OVERSAMPLE_RATE, 16'd17);
    write_reg(CFG_USED_CHANNELS, 16'd9);
    write_reg(CFG_DEADBAND, 16'd255);
    write_reg(CFG_IDLE_DEADBAND, 16'd0);
    for (k = 0; k < 2 * 16; k++) begin
      for (c = 0; c < CHANNELS; c++) send_sample(SAMPLE_W'(c * 500 + 7), CHAN_W'(c));
    end
    wait_quiet();
    write_reg(CFG_OVERSAMPLE_RATE, 16'd16);
    write_reg(CFG_USED_CHANNELS, 16'd1);
    write_reg(CFG_DEADBAND, 16'd0);
    write_reg(CFG_IDLE_RELOAD, 16'hffff);
    for (k = 0; k < 3 * 16; k++) send_sample(12'hfff, 3'd0);
    wait_quiet();
  endtask

  // Random traffic under one idling phase. Most of it is well-formed scans
  // with drifting levels; the rest is random noise and scans cut short. Each
  // stretch begins with the sender held off until every report has come.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int stretch;
    int stretch_len;
    int step;
    int roll;
    int got;
    int c;
    int stop;
    logic [CHAN_W-1:0] ch;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_quiet();
      pick_settings();
      stretch_len = eff_rate() * eff_channels() * 4;
      if (stretch_len < 30) stretch_len = 30;
      if (stretch_len > 130) stretch_len = 130;
      case ($urandom_range(5))
        0: step = 0;
        1: step = 1;
        2: step = 2;
        3: step = 5;
        4: step = 12;
        default: step = 30;
      endcase
      for (c = 0; c < CHANNELS; c++) begin
        if ($urandom_range(3) == 0) chan_level[c] = int'($urandom_range(0, 4095));
      end
      stretch = 0;
      while (stretch < stretch_len) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
          if (int'(ch) < eff_channels()) stretch++;
          send_sample(SAMPLE_W'($urandom_range(0, 4095)), ch);
        end else if (roll < 13) begin
          // A scan broken off before its top channel; the pass does not end.
          stop = $urandom_range(0, eff_channels() - 1);
          for (c = 0; c < stop; c++) begin
            send_sample(SAMPLE_W'(clamp_sample(chan_level[c])), CHAN_W'(c));
            stretch++;
          end
        end else begin
          send_scan(step, got);
          stretch += got;
        end
      end
      sent += stretch;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.channel = '0;
    out_if.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    deadband_r = DEADBAND_RST;
    idle_band_r = IDLE_DEADBAND_RST;
    idle_reload_r = IDLE_RELOAD_RST;
    rate_r = RATE_RST;
    used_r = USED_CH_RST;
    pass_cnt = '0;
    group_cnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      acc_sum[i] = '0;
      chan_level[i] = 2048;
    end
    for (int i = 0; i < PINS; i++) begin
      held_val[i] = '0;
      idle_left[i] = '0;
      last_raw[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_corner_settings();
    test_slowest_rate();
    test_random_traffic(0, 0, 70);
    test_random_traffic(59, 0, 70);
    test_random_traffic(0, 59, 70);
    test_random_traffic(12, 12, 70);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
